>>> rtl/desa_pkg.sv
// Shared types and constants for the double-ended stack allocator.
// Used by desa_cell and double_ended_stack_allocator_top; depends on nothing.
package desa_pkg;

    // Parameter defaults
    localparam int MARKS_PER_SIDE_DEF = 32;
    localparam int ADDR_BITS_DEF      = 28;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ID_W   = 8;
    localparam int TOP_W  = 29;
    localparam int MASK_W = 28;
    localparam int STAT_W = 3;

    // Reset value of the region size register
    localparam logic [TOP_W-1:0] MEM_SIZE_RST = TOP_W'(32'h1000_0000);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_OOM      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_LAST = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // Control broadcast from the sequencer to every mark cell
    typedef struct packed {
        logic             tok_load;   // put the search token on the first cell
        logic             tok_up;     // token moves to the next higher cell
        logic             tok_down;   // token moves to the next lower cell
        logic             clr;        // clear the name under the token
        logic             push;       // write a new mark
        logic             push_side;  // side that receives the mark
        logic [ID_W-1:0]  id;         // name to write or to look for
        logic [TOP_W-1:0] pos;        // position to record on push
    } t_cell_ctl;

endpackage

>>> rtl/desa_cell.sv
// One mark cell: holds a mark name and position plus the walking token bit.
// Depends on desa_pkg; instantiated in a row by double_ended_stack_allocator_top.
module desa_cell #(
    parameter int MARKS_PER_SIDE = desa_pkg::MARKS_PER_SIDE_DEF,
    parameter int G              = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  desa_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(MARKS_PER_SIDE+1)-1:0] i_count,
    input  logic                              i_tok_below,
    input  logic                              i_tok_above,
    output logic                              o_tok,
    output logic                              o_hit,
    output logic                              o_last,
    output logic                              o_name_nz,
    output logic [desa_pkg::TOP_W-1:0]        o_pos
);
    localparam int CNTW = $clog2(MARKS_PER_SIDE + 1);
    localparam logic SIDE = (G >= MARKS_PER_SIDE);
    localparam logic [CNTW-1:0] IDX  = CNTW'(G % MARKS_PER_SIDE);
    localparam logic [CNTW-1:0] IDX1 = CNTW'(G % MARKS_PER_SIDE + 1);

    logic                         r_tok;
    logic [desa_pkg::ID_W-1:0]    r_name;
    logic [desa_pkg::TOP_W-1:0]   r_pos;

    // token loads onto cell 0 or walks to a neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.tok_load) begin
            r_tok <= (G == 0);
        end else if (i_ctl.tok_up) begin
            r_tok <= i_tok_below;
        end else if (i_ctl.tok_down) begin
            r_tok <= i_tok_above;
        end
    end

    // mark contents: push writes the slot at the side's count, clr empties the name under the token
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && i_ctl.push_side == SIDE && i_count == IDX) begin
            r_name <= i_ctl.id;
            r_pos  <= i_ctl.pos;
        end else if (i_ctl.clr && r_tok) begin
            r_name <= '0;
        end
    end

    assign o_tok     = r_tok;
    assign o_hit     = r_tok && (IDX < i_count) && (r_name == i_ctl.id);
    assign o_last    = r_tok && (IDX1 == i_count);
    assign o_name_nz = r_tok && (r_name != '0);
    assign o_pos     = r_tok ? r_pos : '0;

endmodule

>>> rtl/double_ended_stack_allocator_top.sv
// Double-ended stack allocator: low side bumps up from 0, high side down from the size.
// Marks live in a row of desa_cell instances (low side cells first, then high side).
// Sequence: init and push pass through the EXEC and DONE states, allocate through EXEC,
// ALC2, ALC3 and DONE, and a free walks a token up through the mark cells one cell per
// cycle to search, then back down over the freed marks that it pops.
// One command is in flight at a time; a finished result waits in the output register
// while the next command is taken. The region size register applies at the next init.
module double_ended_stack_allocator_top #(
    parameter int MARKS_PER_SIDE = desa_pkg::MARKS_PER_SIDE_DEF,
    parameter int ADDR_BITS      = desa_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // mark_id[7:0], alloc_size[36:8], align_mask[64:37]
    input  logic [2:0]  i_s_axis_tuser,   // cmd[1:0], side[2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // address[28:0], shortfall[57:29]
    output logic [2:0]  o_m_axis_tuser,   // status[2:0]
    input  logic        i_cfg_wr_en,
    input  logic [28:0] i_cfg_wr_data     // memory_size
);
    localparam int TW   = desa_pkg::TOP_W;
    localparam int CNTW = $clog2(MARKS_PER_SIDE + 1);
    localparam int NC   = 2 * MARKS_PER_SIDE;
    localparam int CW   = (ADDR_BITS + 2 > 33) ? ADDR_BITS + 2 : 33;
    localparam logic [CW-1:0] WIDE = CW'((65'd1 << (ADDR_BITS + 1)) - 65'd1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MARKS_PER_SIDE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ALC2 = 3'd2;
    localparam logic [2:0] S_ALC3 = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_POP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                     r_state, n_state;
    logic [TW-1:0]                  r_mem_size;
    logic [TW-1:0]                  r_top [2];
    logic [CNTW-1:0]                r_cnt [2];
    logic [desa_pkg::CMD_W-1:0]     r_cmd;
    logic                           r_side;
    logic [desa_pkg::ID_W-1:0]      r_id;
    logic [TW-1:0]                  r_size;
    logic [desa_pkg::MASK_W-1:0]    r_mask;
    logic [CW-1:0]                  r_start, r_end;
    logic                           r_fs;
    logic [TW-1:0]                  r_addr, r_short;
    logic [desa_pkg::STAT_W-1:0]    r_stat;
    logic                           r_ovalid;
    logic [TW-1:0]                  r_oaddr, r_oshort;
    logic [desa_pkg::STAT_W-1:0]    r_ostat;

    desa_pkg::t_cell_ctl ctl;
    logic [NC-1:0]       tok, hit, last, name_nz;
    logic [TW-1:0]       cpos [NC];
    logic [TW-1:0]       tok_pos;
    logic                hit_any, last_any, hit_hi, tname_nz;
    logic [CW-1:0]       mask_n, top0_x, top1_x, size_x, diff;
    logic                accept;

    // mark cell row
    for (genvar g = 0; g < NC; g++) begin : g_cell
        logic tb, ta;
        if (g == 0) begin : g_b0
            assign tb = 1'b0;
        end else begin : g_b1
            assign tb = tok[g-1];
        end
        if (g == NC - 1) begin : g_a0
            assign ta = 1'b0;
        end else begin : g_a1
            assign ta = tok[g+1];
        end
        desa_cell #(
            .MARKS_PER_SIDE(MARKS_PER_SIDE),
            .G             (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_count    (r_cnt[g / MARKS_PER_SIDE]),
            .i_tok_below(tb),
            .i_tok_above(ta),
            .o_tok      (tok[g]),
            .o_hit      (hit[g]),
            .o_last     (last[g]),
            .o_name_nz  (name_nz[g]),
            .o_pos      (cpos[g])
        );
    end

    // gather what the token cell reports
    always_comb begin
        tok_pos = '0;
        for (int k = 0; k < NC; k++) begin
            tok_pos = tok_pos | cpos[k];
        end
        hit_any  = |hit;
        last_any = |last;
        hit_hi   = |hit[NC-1:MARKS_PER_SIDE];
        tname_nz = |name_nz;
    end

    // allocate arithmetic operands
    assign mask_n = {{(CW - desa_pkg::MASK_W){1'b1}}, ~r_mask};
    assign top0_x = {{(CW - TW){1'b0}}, r_top[0]};
    assign top1_x = {{(CW - TW){1'b0}}, r_top[1]};
    assign size_x = {{(CW - TW){1'b0}}, r_size};
    assign diff   = r_side ? (top0_x - r_end) : (r_end - top1_x);

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // sequencer next state and cell control
    always_comb begin
        n_state       = r_state;
        ctl           = '0;
        ctl.id        = r_id;
        ctl.push_side = r_side;
        ctl.pos       = r_top[r_side];
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                case (r_cmd)
                    desa_pkg::CMD_ALLOC: n_state = S_ALC2;
                    desa_pkg::CMD_FREE: begin
                        if (r_id == '0) begin
                            n_state = S_DONE;
                        end else begin
                            ctl.tok_load = 1'b1;
                            n_state      = S_SRCH;
                        end
                    end
                    desa_pkg::CMD_PUSH: begin
                        ctl.push = (r_cnt[r_side] < FULL_CNT);
                        n_state  = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ALC2: n_state = S_ALC3;
            S_ALC3: n_state = S_DONE;
            S_SRCH: begin
                if (hit_any) begin
                    ctl.clr = 1'b1;
                    n_state = last_any ? S_POP : S_DONE;
                end else if (tok[NC-1]) begin
                    n_state = S_DONE;
                end else begin
                    ctl.tok_up = 1'b1;
                end
            end
            S_POP: begin
                if (r_cnt[r_fs] == '0 || tname_nz) begin
                    n_state = S_DONE;
                end else begin
                    ctl.tok_down = 1'b1;
                end
            end
            S_DONE: if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state, tops and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mem_size <= desa_pkg::MEM_SIZE_RST;
            r_top[0]   <= '0;
            r_top[1]   <= desa_pkg::MEM_SIZE_RST & WIDE[TW-1:0];
            r_cnt[0]   <= '0;
            r_cnt[1]   <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_mem_size <= i_cfg_wr_data;
            if (r_state == S_EXEC && r_cmd == desa_pkg::CMD_INIT) begin
                r_top[0] <= '0;
                r_top[1] <= r_mem_size & WIDE[TW-1:0];
                r_cnt[0] <= '0;
                r_cnt[1] <= '0;
            end
            if (ctl.push) r_cnt[r_side] <= r_cnt[r_side] + 1'b1;
            if (r_state == S_ALC3 && !(!diff[CW-1] && diff != '0)) begin
                r_top[r_side] <= r_side ? r_end[TW-1:0] : r_end[TW-1:0];
            end
            if (ctl.tok_down) begin
                r_top[r_fs] <= tok_pos;
                r_cnt[r_fs] <= r_cnt[r_fs] - 1'b1;
            end
            // output word register
            if (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // command capture, allocate datapath and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_axis_tuser[1:0];
            r_side <= i_s_axis_tuser[2];
            r_id   <= i_s_axis_tdata[7:0];
            r_size <= i_s_axis_tdata[36:8];
            r_mask <= i_s_axis_tdata[64:37];
        end
        unique case (r_state)
            S_EXEC: begin
                r_addr  <= '0;
                r_short <= '0;
                r_stat  <= desa_pkg::ST_OK;
                r_start <= r_side ? ((top1_x - size_x) & mask_n)
                                  : ((top0_x + {{(CW - desa_pkg::MASK_W){1'b0}}, r_mask})
                                     & mask_n);
                if (r_cmd == desa_pkg::CMD_PUSH && r_cnt[r_side] >= FULL_CNT) begin
                    r_stat <= desa_pkg::ST_FULL;
                end
                if (r_cmd == desa_pkg::CMD_FREE && r_id == '0) begin
                    r_stat <= desa_pkg::ST_NOTFOUND;
                end
            end
            S_ALC2: r_end <= r_side ? r_start : (r_start + size_x);
            S_ALC3: begin
                if (!diff[CW-1] && diff != '0) begin
                    r_stat  <= desa_pkg::ST_OOM;
                    r_short <= (diff > WIDE) ? WIDE[TW-1:0] : diff[TW-1:0];
                end else begin
                    r_addr <= r_start[TW-1:0];
                end
            end
            S_SRCH: begin
                r_fs <= hit_hi;
                if (hit_any) begin
                    if (!last_any) r_stat <= desa_pkg::ST_NOT_LAST;
                end else if (tok[NC-1]) begin
                    r_stat <= desa_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) begin
            r_oaddr  <= r_addr;
            r_oshort <= r_short;
            r_ostat  <= r_stat;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_oshort, r_oaddr};
    assign o_m_axis_tuser  = r_ostat;

endmodule

>>> tb/sv/desa_result_checker.sv
// Result checker for the double-ended stack allocator testbench.
// Watches the command, result and size-register ports; depends on desa_pkg.
`timescale 1ns / 100ps

module desa_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] i_m_axis_tdata,
    input  logic [2:0]  i_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [28:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_words_owed
);
    localparam int SIDE_MARKS = desa_pkg::MARKS_PER_SIDE_DEF;
    localparam longint unsigned SHORT_CAP = (64'd1 << (desa_pkg::ADDR_BITS_DEF + 1)) - 1;
    localparam longint unsigned FIELD_MASK = (64'd1 << 29) - 1;

    typedef struct {
        logic [28:0] address;
        logic [28:0] missing;
        logic [2:0]  status;
    } t_alloc_result;

    // Allocator state as the block should hold it
    longint unsigned region_size;
    longint unsigned top_of[2];
    int unsigned     marks_on[2];
    longint unsigned mark_pos[2*SIDE_MARKS];
    logic [7:0]      mark_tag[2*SIDE_MARKS];

    t_alloc_result   owed_q[$];
    int              fails;

    assign o_fail_count = fails;
    assign o_words_owed = owed_q.size();

    function automatic longint unsigned cap_missing(longint unsigned v);
        return (v > SHORT_CAP) ? SHORT_CAP : v;
    endfunction

    // Work out the result of one command and advance the state
    task automatic allocate_step(input logic [1:0] cmd, input logic side, input logic [7:0] id,
                                 input logic [28:0] req, input logic [27:0] amask,
                                 output t_alloc_result res);
        longint unsigned addr, miss, start, stop, msk;
        logic [2:0] st;
        bit found;
        int fs, fi, k;
        addr = 0; miss = 0; st = desa_pkg::ST_OK; found = 0; fs = 0; fi = 0;
        msk = {36'd0, amask};
        case (cmd)
            desa_pkg::CMD_INIT: begin
                top_of[0] = 0;
                top_of[1] = region_size;
                marks_on[0] = 0;
                marks_on[1] = 0;
            end
            desa_pkg::CMD_PUSH: begin
                if (marks_on[side] >= SIDE_MARKS) begin
                    st = desa_pkg::ST_FULL;
                end else begin
                    k = side * SIDE_MARKS + marks_on[side];
                    mark_tag[k] = id;
                    mark_pos[k] = top_of[side];
                    marks_on[side]++;
                end
            end
            desa_pkg::CMD_ALLOC: begin
                if (side == 1'b0) begin
                    start = (top_of[0] + msk) & ~msk;
                    stop  = start + req;
                    if (stop > top_of[1]) begin
                        st = desa_pkg::ST_OOM;
                        miss = cap_missing(stop - top_of[1]);
                    end else begin
                        top_of[0] = stop;
                        addr = start;
                    end
                end else begin
                    start = (top_of[1] - req) & ~msk;
                    if ($signed(start) < $signed(top_of[0])) begin
                        st = desa_pkg::ST_OOM;
                        miss = cap_missing(top_of[0] - start);
                    end else begin
                        top_of[1] = start;
                        addr = start;
                    end
                end
            end
            default: begin
                // low side searched first, bottom entry up
                if (id != 0) begin
                    for (int t = 0; t < 2 && !found; t++)
                        for (int i = 0; i < marks_on[t] && !found; i++)
                            if (mark_tag[t*SIDE_MARKS + i] == id) begin
                                found = 1; fs = t; fi = i;
                            end
                end
                if (!found) begin
                    st = desa_pkg::ST_NOTFOUND;
                end else begin
                    mark_tag[fs*SIDE_MARKS + fi] = 8'd0;
                    if (fi != marks_on[fs] - 1) begin
                        st = desa_pkg::ST_NOT_LAST;
                    end else begin
                        // rewind, then pop freed marks left on top
                        forever begin
                            top_of[fs] = mark_pos[fs*SIDE_MARKS + fi];
                            marks_on[fs]--;
                            if (marks_on[fs] == 0) break;
                            fi = marks_on[fs] - 1;
                            if (mark_tag[fs*SIDE_MARKS + fi] != 0) break;
                        end
                    end
                end
            end
        endcase
        res.address = 29'(addr & FIELD_MASK);
        res.missing = 29'(miss & FIELD_MASK);
        res.status  = st;
    endtask

    always @(posedge i_clk) begin
        t_alloc_result got, want;
        if (!i_rst_n) begin
            region_size = 64'h1000_0000;
            top_of[0] = 0;
            top_of[1] = region_size;
            marks_on[0] = 0;
            marks_on[1] = 0;
            owed_q.delete();
            fails = 0;
        end else begin
            // result words first: none can stem from a command taken at this edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.address = i_m_axis_tdata[28:0];
                got.missing = i_m_axis_tdata[57:29];
                got.status  = i_m_axis_tuser;
                if (owed_q.size() == 0) begin
                    $error("result word with nothing outstanding: addr=%0h status=%0d",
                           got.address, got.status);
                    fails++;
                end else begin
                    want = owed_q.pop_front();
                    if (got.address !== want.address) begin
                        $error("address: expected %0h, got %0h", want.address, got.address);
                        fails++;
                    end
                    if (got.missing !== want.missing) begin
                        $error("shortfall: expected %0h, got %0h", want.missing, got.missing);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en)
                region_size = {35'd0, i_cfg_wr_data};
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                allocate_step(i_s_axis_tuser[1:0], i_s_axis_tuser[2], i_s_axis_tdata[7:0],
                              i_s_axis_tdata[36:8], i_s_axis_tdata[64:37], want);
                owed_q.push_back(want);
            end
        end
    end

endmodule

>>> tb/sv/double_ended_stack_allocator_top_tb.sv
// Testbench top for the double-ended stack allocator: drives commands and size writes,
// stalls the result side, and reports the verdict. Depends on desa_pkg, desa_result_checker.
`timescale 1ns / 100ps

module double_ended_stack_allocator_top_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // mark_id[7:0], alloc_size[36:8], align_mask[64:37]
    logic [2:0]  s_tuser = '0;   // cmd[1:0], side[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // address[28:0], shortfall[57:29]
    logic [2:0]  m_tuser;        // status[2:0]
    logic        cfg_wr_en = 1'b0;
    logic [28:0] cfg_wr_data = '0;

    int  fail_count, words_owed;
    bit  no_idle = 0;
    int  ready_hold = 0;
    int  cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    double_ended_stack_allocator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data)
    );

    desa_result_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count), .o_words_owed(words_owed)
    );

    // Result side: a random stall after each accepted word, none while no_idle is set
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (m_tready && m_tvalid) begin
            stall = no_idle ? 0 : int'($urandom_range(0, 3));
            ready_hold <= stall;
            m_tready <= (stall == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= (ready_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One command word, with a random gap before it
    task automatic send_cmd(input logic [1:0] cmd, input logic side, input logic [7:0] id,
                            input logic [28:0] req, input logic [27:0] amask);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, amask, req, id};
        s_tuser  <= {side, cmd};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Hold the sender off, then wait until all results are back
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_owed != 0);
    endtask

    task automatic write_size(input logic [28:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic rand_side();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [28:0] pick_req(input logic [28:0] region);
        case ($urandom_range(0, 9))
            0: return 29'($urandom_range(1, 32'h1000_0000));
            1: return region;
            2: return (region > 2) ? region / 2 : 29'd1;
            default: return 29'($urandom_range(1, (region > 64) ? 32'(region / 16) : 32'd4));
        endcase
    endfunction

    function automatic logic [27:0] pick_mask();
        case ($urandom_range(0, 7))
            0: return 28'($urandom);
            1: return 28'hFFF_FFFF;
            2: return 28'd0;
            default: return (28'd1 << $urandom_range(0, 6)) - 28'd1;
        endcase
    endfunction

    logic [28:0] sizes[6];

    initial begin
        sizes = '{29'd1, 29'h1000_0000, 29'd4096, 29'd300, 29'd0, 29'd77};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default region of 2^28 bytes
        send_cmd(desa_pkg::CMD_INIT, 1'b0, 8'd0, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'h1000_0000, 28'hFFF_FFFF);  // past end
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'd3, 28'hF);
        send_cmd(desa_pkg::CMD_PUSH, 1'b0, 8'd5, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_PUSH, 1'b1, 8'd0, 29'd1, 28'd0);    // empty-named mark
        send_cmd(desa_pkg::CMD_FREE, 1'b0, 8'd0, 29'd1, 28'd0);    // empty name never found
        send_cmd(desa_pkg::CMD_FREE, 1'b1, 8'd99, 29'd1, 28'd0);   // absent name
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'd100, 28'd0);
        send_cmd(desa_pkg::CMD_PUSH, 1'b0, 8'd6, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b1, 8'd0, 29'd64, 28'h3F);
        send_cmd(desa_pkg::CMD_FREE, 1'b0, 8'd5, 29'd1, 28'd0);    // not the last mark
        send_cmd(desa_pkg::CMD_FREE, 1'b0, 8'd6, 29'd1, 28'd0);    // last: pops freed below
        send_cmd(desa_pkg::CMD_ALLOC, 1'b1, 8'd0, 29'h1000_0000, 28'd0);  // start below zero
        send_cmd(desa_pkg::CMD_PUSH, 1'b1, 8'd255, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b1, 8'd0, 29'd1, 28'hFFF_FFFF);
        send_cmd(desa_pkg::CMD_FREE, 1'b1, 8'd255, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_INIT, 1'b0, 8'd0, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'h1000_0000, 28'd0);  // exact fit
        send_cmd(desa_pkg::CMD_ALLOC, 1'b1, 8'd0, 29'd1, 28'd0);
        send_cmd(desa_pkg::CMD_ALLOC, 1'b0, 8'd0, 29'd1, 28'd0);

        // Random phases over several region sizes
        for (int ph = 0; ph < 6; ph++) begin
            logic [28:0] region;
            region = (sizes[ph] == 0) ? 29'($urandom_range(1, 32'h1000_0000)) : sizes[ph];
            write_size(region);
            no_idle = (ph == 2);
            send_cmd(desa_pkg::CMD_INIT, rand_side(), 8'd0, 29'd1, 28'd0);
            for (int n = 0; n < 68; n++) begin
                int roll;
                roll = int'($urandom_range(0, 99));
                if (roll < 2) begin
                    logic sd;
                    sd = rand_side();
                    for (int j = 0; j < 34; j++)
                        send_cmd(desa_pkg::CMD_PUSH, sd, pick_id(), pick_req(region),
                                 pick_mask());
                end else if (roll < 5) begin
                    send_cmd(desa_pkg::CMD_INIT, rand_side(), pick_id(), pick_req(region),
                             pick_mask());
                end else if (roll < 35) begin
                    send_cmd(desa_pkg::CMD_PUSH, rand_side(), pick_id(), pick_req(region),
                             pick_mask());
                end else if (roll < 68) begin
                    send_cmd(desa_pkg::CMD_ALLOC, rand_side(), pick_id(), pick_req(region),
                             pick_mask());
                end else begin
                    send_cmd(desa_pkg::CMD_FREE, rand_side(), pick_id(), pick_req(region),
                             pick_mask());
                end
            end
        end

        no_idle = 0;
        drain();
        repeat (120) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
